@@ hdl/dda4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda4_pkg
// Shared constants for the four-axis DDA step interpolator: item codes,
// field widths and parameter defaults.
// ----------------------------------------------------------------------------
package dda4_pkg;

  // Parameter defaults
  localparam int AXIS_COUNT_DEF = 4;
  localparam int COUNT_BITS_DEF = 31;

  // Axes carried on the ports (X, Y, Z, A)
  localparam int SHOWN_AXES  = 4;
  localparam int WORD_BITS   = 32;
  localparam int REMAIN_BITS = 31;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

endpackage

@@ hdl/dda_four_axis_step_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_four_axis_step_interpolator
// Four-axis DDA line interpolator: load a move, then tick out step pulses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item. func at
//   FUNC_LOAD loads a move from the four signed pulse counts; func at
//   FUNC_TICK runs one interpolation tick. Output channel (out_valid /
//   out_stall) returns exactly one result beat per input beat, in order.
//   A beat accepted at one edge is registered and appears on the output
//   after that edge. Throughput is one item per clock unless the receiver
//   stalls, set by the single next-state pass (one add, compare and subtract
//   per axis, or a negate, saturate and compare chain on a load).
//   The result register parts the two channels: a new beat is accepted
//   whenever the result register is empty or its beat is taken in the same
//   cycle. While the receiver stalls a held result, in_stall is raised and
//   the result and all move state hold.
//   Reset (rst, synchronous) empties the result register, clears counts,
//   accumulators, positions and ticks left, and sets every direction to
//   forward. A tick with no ticks left changes nothing and reports no steps.
// ----------------------------------------------------------------------------
module dda_four_axis_step_interpolator
  import dda4_pkg::*;
#(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic signed [WORD_BITS-1:0]   x_steps,
  input  logic signed [WORD_BITS-1:0]   y_steps,
  input  logic signed [WORD_BITS-1:0]   z_steps,
  input  logic signed [WORD_BITS-1:0]   a_steps,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SHOWN_AXES-1:0]         step_mask,
  output logic [SHOWN_AXES-1:0]         dir_mask,
  output logic [REMAIN_BITS-1:0]        remaining,
  output logic                          move_done,
  output logic signed [WORD_BITS-1:0]   pos_x,
  output logic signed [WORD_BITS-1:0]   pos_y,
  output logic signed [WORD_BITS-1:0]   pos_z,
  output logic signed [WORD_BITS-1:0]   pos_a
);

  localparam int AXIS_BITS = $clog2(AXIS_COUNT);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  // Move state
  count_t                 axis_count    [AXIS_COUNT];
  count_t                 axis_accum    [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]  axis_dir;
  word_t                  axis_position [AXIS_COUNT];
  logic [AXIS_BITS-1:0]   major_axis;
  count_t                 major_count;
  count_t                 ticks_left;

  count_t                 axis_count_next    [AXIS_COUNT];
  count_t                 axis_accum_next    [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]  axis_dir_next;
  word_t                  axis_position_next [AXIS_COUNT];
  logic [AXIS_BITS-1:0]   major_axis_next;
  count_t                 major_count_next;
  count_t                 ticks_left_next;
  logic [AXIS_COUNT-1:0]  step_next;

  // Per-axis load value and saturated magnitude
  word_t                  load_val [AXIS_COUNT];
  count_t                 load_mag [AXIS_COUNT];

  // Port-order views of the next state
  word_t                  in_words [SHOWN_AXES];
  logic [SHOWN_AXES-1:0]  shown_step;
  logic [SHOWN_AXES-1:0]  shown_dir;
  word_t                  shown_pos [SHOWN_AXES];

  logic                   in_accept;

  // Accept while the result register is empty or being emptied.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign in_words[0] = word_t'(x_steps);
  assign in_words[1] = word_t'(y_steps);
  assign in_words[2] = word_t'(z_steps);
  assign in_words[3] = word_t'(a_steps);

  // Axes past the fourth load a count of zero.
  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_load
    word_t abs_val;
    if (g < SHOWN_AXES) begin : g_port
      assign load_val[g] = in_words[g];
    end else begin : g_zero
      assign load_val[g] = '0;
    end
    assign abs_val     = load_val[g][WORD_BITS-1] ? (~load_val[g] + word_t'(1)) : load_val[g];
    // saturate anything above the count range
    assign load_mag[g] = (abs_val[WORD_BITS-1:COUNT_BITS] != '0) ? '1
                                                               : abs_val[COUNT_BITS-1:0];
  end

  // Next-state pass: load or one tick.
  always_comb begin
    logic [COUNT_BITS:0]  sum;
    count_t               best;
    logic [AXIS_BITS-1:0] best_i;

    sum                = '0;
    best               = '0;
    best_i             = '0;
    axis_count_next    = axis_count;
    axis_accum_next    = axis_accum;
    axis_dir_next      = axis_dir;
    axis_position_next = axis_position;
    major_axis_next    = major_axis;
    major_count_next   = major_count;
    ticks_left_next    = ticks_left;
    step_next          = '0;

    if (func == FUNC_LOAD) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        axis_dir_next[i]   = ~load_val[i][WORD_BITS-1];
        axis_count_next[i] = load_mag[i];
        axis_accum_next[i] = load_mag[i];
        // strict compare keeps the earliest axis on a tie
        if (load_mag[i] > best) begin
          best   = load_mag[i];
          best_i = AXIS_BITS'(i);
        end
      end
      major_axis_next  = best_i;
      major_count_next = best;
      ticks_left_next  = best;
    end else if (ticks_left != '0) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        if (major_axis == AXIS_BITS'(i)) begin
          step_next[i] = 1'b1;
        end else begin
          sum = {1'b0, axis_accum[i]} + {1'b0, axis_count[i]};
          if (sum >= {1'b0, major_count}) begin
            sum          = sum - {1'b0, major_count};
            step_next[i] = 1'b1;
          end
          axis_accum_next[i] = sum[COUNT_BITS-1:0];
        end
        if (step_next[i]) begin
          axis_position_next[i] = axis_dir[i] ? (axis_position[i] + word_t'(1))
                                              : (axis_position[i] - word_t'(1));
        end
      end
      ticks_left_next = ticks_left - count_t'(1);
    end
  end

  // Map axes onto the four port lanes; missing axes read as zero.
  for (genvar g = 0; g < SHOWN_AXES; g++) begin : g_show
    if (g < AXIS_COUNT) begin : g_axis
      assign shown_step[g] = step_next[g];
      assign shown_dir[g]  = axis_dir_next[g];
      assign shown_pos[g]  = axis_position_next[g];
    end else begin : g_none
      assign shown_step[g] = 1'b0;
      assign shown_dir[g]  = 1'b0;
      assign shown_pos[g]  = '0;
    end
  end

  // Move state: advance on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        axis_count[i]    <= '0;
        axis_accum[i]    <= '0;
        axis_position[i] <= '0;
      end
      axis_dir    <= '1;
      major_axis  <= '0;
      major_count <= '0;
      ticks_left  <= '0;
    end else if (in_accept) begin
      axis_count    <= axis_count_next;
      axis_accum    <= axis_accum_next;
      axis_position <= axis_position_next;
      axis_dir      <= axis_dir_next;
      major_axis    <= major_axis_next;
      major_count   <= major_count_next;
      ticks_left    <= ticks_left_next;
    end
  end

  // Result register valid: fill on accept, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: hold unless a new beat is accepted.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      step_mask <= shown_step;
      dir_mask  <= shown_dir;
      remaining <= REMAIN_BITS'(ticks_left_next);
      move_done <= (ticks_left_next == '0);
      pos_x     <= shown_pos[0];
      pos_y     <= shown_pos[1];
      pos_z     <= shown_pos[2];
      pos_a     <= shown_pos[3];
    end
  end

endmodule
